// ===== rtl/tdpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Trial division prime test: shared types and constants
// Sequencer states and the first trial divisor.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV
  } state_t;

  // Smallest trial divisor and its square
  localparam int unsigned FIRST_DIVISOR = 2;
  localparam int unsigned FIRST_SQUARE  = FIRST_DIVISOR * FIRST_DIVISOR;

endpackage

// ===== rtl/trial_division_prime_test_core.sv =====
// ----------------------------------------------------------------------------
// Trial division prime test core
// Tests one unsigned number for primality by trial division with a bit-serial
// restoring remainder unit.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Signals
//  --------  -------------------  -------------------------------------------
//  input     start & !busy        candidate
//  result    done (one cycle)     tested_value, is_prime
//
//  Each trial divisor first compares d*d with the number in ST_CHECK, then
//  the remainder unit shifts in one dividend bit per cycle in ST_DIV. done
//  rises when a divisor divides the number, or, for a prime, when d*d passes
//  it; 0 and 1 return in the cycle after the transfer. Worst case at 27 bits
//  (a prime near 2^27) is 11584 divisors.
//  Synchronous reset returns the sequencer to idle. The receiver cannot
//  stall; done pulses for one cycle and a new item may transfer that cycle.
//
module trial_division_prime_test_core
  import tdpt_pkg::*;
#(
  parameter int VALUE_WIDTH = 27
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] candidate,
  output logic                   busy,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] tested_value,
  output logic                   is_prime
);

  localparam int DW = (VALUE_WIDTH + 1) / 2 + 1;  // divisor width
  localparam int SW = VALUE_WIDTH + 1;            // square width
  localparam int CW = $clog2(VALUE_WIDTH);        // bit counter width

  state_t state, state_next;

  logic [VALUE_WIDTH-1:0] value;
  logic [VALUE_WIDTH-1:0] dividend;
  logic [DW-1:0]          divisor;
  logic [SW-1:0]          square;
  logic [DW-1:0]          rem;
  logic [CW-1:0]          bit_cnt;

  logic [DW:0]   trial;
  logic [DW:0]   trial_sub;
  logic          trial_ge;
  logic [DW-1:0] rem_step;
  logic          last_bit;
  logic          square_over;
  logic          small_value;

  // Next value of the restoring step
  assign trial     = {rem, dividend[VALUE_WIDTH-1]};
  assign trial_ge  = trial >= {1'b0, divisor};
  assign trial_sub = trial - {1'b0, divisor};
  assign rem_step  = trial_ge ? trial_sub[DW-1:0] : trial[DW-1:0];
  assign last_bit  = bit_cnt == CW'(VALUE_WIDTH - 1);

  assign square_over = square > {1'b0, value};
  assign small_value = candidate < VALUE_WIDTH'(FIRST_DIVISOR);

  assign busy         = state != ST_IDLE;
  assign tested_value = value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && !small_value) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = square_over ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (last_bit) begin
          state_next = (rem_step == '0) ? ST_IDLE : ST_CHECK;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Result strobe and flag
  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      is_prime <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start && small_value) begin
            done     <= 1'b1;
            is_prime <= 1'b0;
          end
        end
        ST_CHECK: begin
          if (square_over) begin
            done     <= 1'b1;
            is_prime <= 1'b1;
          end
        end
        ST_DIV: begin
          if (last_bit && rem_step == '0) begin
            done     <= 1'b1;
            is_prime <= 1'b0;
          end
        end
        default: done <= 1'b0;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          value   <= candidate;
          divisor <= DW'(FIRST_DIVISOR);
          square  <= SW'(FIRST_SQUARE);
        end
      end
      ST_CHECK: begin
        dividend <= value;
        rem      <= '0;
        bit_cnt  <= '0;
      end
      ST_DIV: begin
        rem      <= rem_step;
        dividend <= {dividend[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt  <= bit_cnt + 1'b1;
        if (last_bit) begin
          // advance: (d+1)^2 = d^2 + 2d + 1
          divisor <= divisor + 1'b1;
          square  <= square + SW'({divisor, 1'b1});
        end
      end
      default: rem <= '0;
    endcase
  end

endmodule

// ===== rtl/tdpt_checker.sv =====
// ----------------------------------------------------------------------------
// Trial division prime test: port checker
// Watches the top level's ports for sequencing and result consistency.
// ----------------------------------------------------------------------------
module tdpt_checker #(
  parameter int VALUE_WIDTH = 27
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   done,
  input logic [VALUE_WIDTH-1:0] tested_value,
  input logic                   is_prime
);

  // Reset leaves the core idle with no result pending
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("core not idle after reset");

  // A transfer starts work or returns a result at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("transfer dropped");

  // Work ends only with a result
  a_end_has_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy fell without a result");

  // A result appears only while idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while busy");

  // Zero and one are never reported prime
  a_small_not_prime: assert property (@(posedge clk) disable iff (rst)
    done && tested_value < VALUE_WIDTH'(2) |-> !is_prime)
    else $error("zero or one reported prime");

endmodule

bind trial_division_prime_test_core tdpt_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_tdpt_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .tested_value (tested_value),
  .is_prime     (is_prime)
);

// ===== tb/sv/trial_division_prime_test_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trial division prime test core: self-checking testbench
// Runs a table of edge-case numbers, then bursts of random numbers, through
// the core. Each transfer is predicted by a local trial divider, or by the table for typed
// rows, and every done pulse is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module trial_division_prime_test_core_tb;
  import tdpt_pkg::*;

  localparam int VW           = 27;
  localparam int N_PROBES     = 21;
  localparam int RANDOM_ITEMS = 80;

  typedef struct packed {
    logic [VW-1:0] value;
    logic          prime;
  } prime_result_t;

  typedef struct packed {
    logic [VW-1:0] value;
    logic          typed;
    logic          prime;
  } probe_t;

  logic          clk;
  logic          rst;
  logic          start;
  logic [VW-1:0] candidate;
  logic          busy;
  logic          done;
  logic [VW-1:0] tested_value;
  logic          is_prime;

  prime_result_t pending_results[$];
  int            error_count;

  // Edge cases: a typed flag marks rows whose answer is obvious at a glance
  probe_t probes[N_PROBES] = '{
    '{27'd0,         1'b1, 1'b0},
    '{27'd1,         1'b1, 1'b0},
    '{27'd2,         1'b1, 1'b1},
    '{27'd3,         1'b1, 1'b1},
    '{27'd4,         1'b1, 1'b0},
    '{27'd5,         1'b0, 1'b0},
    '{27'd7,         1'b0, 1'b0},
    '{27'd9,         1'b0, 1'b0},
    '{27'd25,        1'b0, 1'b0},
    '{27'd49,        1'b0, 1'b0},
    '{27'd97,        1'b0, 1'b0},
    '{27'd9409,      1'b0, 1'b0},
    '{27'd63001,     1'b0, 1'b0},
    '{27'd65521,     1'b0, 1'b0},
    '{27'd65536,     1'b1, 1'b0},
    '{27'd134217727, 1'b0, 1'b0},
    '{27'd134217726, 1'b1, 1'b0},
    '{27'd67108864,  1'b1, 1'b0},
    '{27'd89478485,  1'b0, 1'b0},
    '{27'd44739242,  1'b1, 1'b0},
    '{27'd134217689, 1'b0, 1'b0}
  };

  trial_division_prime_test_core #(
    .VALUE_WIDTH(VW)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .candidate   (candidate),
    .busy        (busy),
    .done        (done),
    .tested_value(tested_value),
    .is_prime    (is_prime)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("trial_division_prime_test_core_tb: done, errors");
    $finish;
  end

  function automatic logic prime_by_trial(input logic [VW-1:0] n);
    longint unsigned num;
    longint unsigned d;
    num = n;
    if (num < 2) return 1'b0;
    for (d = FIRST_DIVISOR; d * d <= num; d++) begin
      if (num % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Mostly small numbers keep the run short; large ones carry a small factor
  // so that the high bits toggle without long prime searches.
  function automatic logic [VW-1:0] pick_candidate();
    int unsigned   sel;
    int unsigned   factor;
    logic [VW-1:0] r;
    int unsigned   small_factors[6] = '{2, 3, 5, 7, 11, 13};
    sel = $urandom_range(0, 99);
    if (sel < 50) return VW'($urandom_range(0, 4095));
    if (sel < 65) return VW'($urandom_range(0, 65535));
    r      = VW'($urandom);
    factor = small_factors[$urandom_range(0, 5)];
    return r - VW'(r % factor);
  endfunction

  // Hold start high until the core takes the number, then log the prediction
  task automatic transfer_number(input logic [VW-1:0] n, input logic typed,
                                 input logic prime);
    prime_result_t res;
    start     <= 1'b1;
    candidate <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
    res.value = n;
    res.prime = typed ? prime : prime_by_trial(n);
    pending_results = {pending_results, res};
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    prime_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: tested_value=%0d is_prime=%0b", tested_value, is_prime);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (tested_value !== want.value) begin
          $error("tested_value: expected %0d, actual %0d", want.value, tested_value);
          error_count++;
        end
        if (is_prime !== want.prime) begin
          $error("is_prime: expected %0b, actual %0b (value %0d)",
                 want.prime, is_prime, want.value);
          error_count++;
        end
      end
    end
  end

  initial begin
    int sent;
    int burst;
    int gap;
    error_count = 0;
    rst       <= 1'b1;
    start     <= 1'b0;
    candidate <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, back to back
    for (int i = 0; i < N_PROBES; i++) begin
      transfer_number(probes[i].value, probes[i].typed, probes[i].prime);
    end
    drain_results();

    // Random bursts with idle gaps; pause for a full drain halfway
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 7) == 0) ? 20 : $urandom_range(1, 8);
      for (int j = 0; j < burst && sent < RANDOM_ITEMS; j++) begin
        transfer_number(pick_candidate(), 1'b0, 1'b0);
        sent++;
        if (sent == RANDOM_ITEMS / 2) drain_results();
      end
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("trial_division_prime_test_core_tb: done, clean");
    end else begin
      $display("trial_division_prime_test_core_tb: done, errors");
    end
    $finish;
  end

endmodule
